// ===== sv/d2s_pkg.sv =====
package d2s_pkg;

    localparam int DblFracBits = 52;
    localparam int DblExpBits  = 11;
    localparam int SglFracBits = 23;
    localparam int DropNormal  = 29;
    localparam int DropLimit   = 54;
    localparam int DblBias     = 1023;
    localparam int SglBias     = 127;

    localparam logic [31:0] SglInf  = 32'h7F80_0000;
    localparam logic [31:0] SglQnan = 32'h7FC0_0000;

    // result class decided in the decode stage
    typedef enum logic [1:0] {
        K_NORM = 2'd0,
        K_ZERO = 2'd1,
        K_INF  = 2'd2,
        K_NAN  = 2'd3
    } t_kind;

    // decode stage to round stage
    typedef struct packed {
        logic        sign;
        t_kind       kind;
        logic [5:0]  shift;
        logic [7:0]  base_exp;
        logic [52:0] mant;
    } t_dec;

    // round stage to pack stage
    typedef struct packed {
        logic        sign;
        t_kind       kind;
        logic [7:0]  base_exp;
        logic [24:0] keep;
        logic        round_up;
    } t_rnd;

endpackage

// ===== sv/d2s_decode.sv =====
module d2s_decode
    import d2s_pkg::*;
(
    input  logic [63:0] i_bits,
    output t_dec        o_dec
);

    logic [10:0] w_exp;
    logic [51:0] w_frac;
    logic signed [12:0] w_fe;

    assign w_exp  = i_bits[62:52];
    assign w_frac = i_bits[51:0];
    assign w_fe   = $signed({2'b00, w_exp}) - 13'sd896;

    // classify and work out the rounding position
    always_comb begin
        o_dec.sign     = i_bits[63];
        o_dec.kind     = K_NORM;
        o_dec.shift    = 6'(DropNormal);
        o_dec.base_exp = 8'd0;
        o_dec.mant     = {1'b1, w_frac};
        if (w_exp == '1) begin
            o_dec.kind = (w_frac != '0) ? K_NAN : K_INF;
        end else if (w_exp == '0) begin
            o_dec.kind = K_ZERO;
        end else if (w_fe >= 13'sd255) begin
            o_dec.kind = K_INF;
        end else if (w_fe >= 13'sd1) begin
            o_dec.base_exp = 8'(w_fe - 13'sd1);
        end else if (w_fe <= 13'(DropNormal + 1 - DropLimit)) begin
            o_dec.kind = K_ZERO;
        end else begin
            o_dec.shift = 6'(13'(DropNormal + 1) - w_fe);
        end
    end

endmodule

// ===== sv/d2s_round.sv =====
module d2s_round
    import d2s_pkg::*;
(
    input  t_dec i_dec,
    output t_rnd o_rnd
);

    logic [52:0] w_keep;
    logic [52:0] w_rem;
    logic [52:0] w_half;

    // split the mantissa at the rounding position, shift is 29..53
    always_comb begin
        w_keep = i_dec.mant >> i_dec.shift;
        w_half = 53'd1 << (i_dec.shift - 6'd1);
        w_rem  = i_dec.mant & ((53'd1 << i_dec.shift) - 53'd1);
        o_rnd.sign     = i_dec.sign;
        o_rnd.kind     = i_dec.kind;
        o_rnd.base_exp = i_dec.base_exp;
        o_rnd.keep     = w_keep[24:0];
        o_rnd.round_up = (w_rem > w_half) || ((w_rem == w_half) && w_keep[0]);
    end

endmodule

// ===== sv/d2s_pack.sv =====
module d2s_pack
    import d2s_pkg::*;
(
    input  t_rnd        i_rnd,
    output logic [31:0] o_bits
);

    logic [31:0] w_mag;

    // add rounding carry into exponent, saturate to infinity
    always_comb begin
        w_mag = {1'b0, i_rnd.base_exp, 23'd0} + {7'd0, i_rnd.keep}
                + {31'd0, i_rnd.round_up};
        if (w_mag >= SglInf) begin
            w_mag = SglInf;
        end
        case (i_rnd.kind)
            K_NAN:   o_bits = SglQnan;
            K_INF:   o_bits = {i_rnd.sign, SglInf[30:0]};
            K_ZERO:  o_bits = {i_rnd.sign, 31'd0};
            default: o_bits = {i_rnd.sign, w_mag[30:0]};
        endcase
    end

endmodule

// ===== sv/double_to_single_convert_core.sv =====
// double to single precision converter, round to nearest, ties to even
//
// slave channel: i_s_tvalid / o_s_tready / i_s_tdata (64 bit binary64 pattern)
// master channel: o_m_tvalid / i_m_tready / o_m_tdata (32 bit binary32 pattern)
// one result per transfer, in order
//
// three register stages: decode, round, pack; throughput is one item per
// cycle while the receiver keeps i_m_tready high
//
// i_rst_n low (synchronous) clears all stage valid bits; payload is not reset
// when the receiver stalls the full stages hold; o_s_tready is
// low only while the output stage holds a result and i_m_tready is low
// and every stage is full; empty stages still fill (bubbles collapse)
module double_to_single_convert_core
    import d2s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // double_bits[63:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // single_bits[31:0]
);

    logic        r_v1, r_v2, r_v3;
    t_dec        r_dec, n_dec;
    t_rnd        r_rnd, n_rnd;
    logic [31:0] r_out, n_out;
    logic        w_en3, w_en2, w_en1;

    d2s_decode u_decode (.i_bits(i_s_tdata), .o_dec(n_dec));
    d2s_round  u_round  (.i_dec(r_dec),     .o_rnd(n_rnd));
    d2s_pack   u_pack   (.i_rnd(r_rnd),     .o_bits(n_out));

    // each stage advances when the one after it is free
    assign w_en3 = !r_v3 || i_m_tready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_s_tready = w_en1;
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_s_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_en1) r_dec <= n_dec;
        if (w_en2) r_rnd <= n_rnd;
        if (w_en3) r_out <= n_out;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_v1 && r_v2 && r_v3 && !i_m_tready)
        else $error("ready dropped with room left");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && w_en3 |=> r_v3)
        else $error("item lost between stages");

endmodule
